@@ sv/sirp_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the set block.
package sirp_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int RND_W    = 16;
    localparam int ACT_W    = 2;
    localparam int ST_W     = 2;
    localparam int MC_W     = 7;
    localparam int STEP_W   = $clog2(RND_W);

    localparam int IN_TDATA_W  = ((VAL_W + RND_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + MC_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_PICK   = 2'd2
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    scan;
        logic    rd_last;
        logic    rd_pick;
        logic    wr_append;
        logic    wr_move;
        logic    div_start;
        logic    div_step;
        logic    res_load;
        t_status res_status;
        logic    res_pick;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic full;
        logic empty;
        logic div_done;
    } t_dp_sts;

endpackage

@@ sv/sirp_dp.sv @@
// Datapath of the set block: member memory, live count, search scan, modulo unit, result register.
module sirp_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sirp_pkg::t_dp_cmd           i_cmd,
    input  logic [sirp_pkg::VAL_W-1:0]  i_value,
    input  logic [sirp_pkg::RND_W-1:0]  i_random_word,
    output sirp_pkg::t_dp_sts           o_sts,
    output sirp_pkg::t_status           o_status,
    output logic [sirp_pkg::VAL_W-1:0]  o_picked_value,
    output logic [sirp_pkg::MC_W-1:0]   o_member_count
);
    import sirp_pkg::*;

    logic [VAL_W-1:0] r_mem [CAPACITY];
    logic [VAL_W-1:0] r_rdata;
    logic [VAL_W-1:0] r_value;
    logic [RND_W-1:0] r_rnd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_pidx;
    logic             r_pend;
    logic [CNT_W-1:0] r_rem;
    logic [STEP_W-1:0] r_step;

    t_status          r_res_status;
    logic [VAL_W-1:0] r_res_picked;
    logic [CNT_W-1:0] r_res_count;

    logic             w_hit;
    logic             w_scan_en;
    logic             w_scan_rd;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [VAL_W-1:0] w_wr_data;
    logic [CNT_W:0]   w_trial;
    logic             w_ge;
    logic [CNT_W-1:0] n_rem;
    logic [CNT_W-1:0] w_last;

    assign w_hit     = r_pend && (r_rdata == r_value);
    // The scan freezes once a match is seen so the matching slot stays put.
    assign w_scan_en = i_cmd.scan && !w_hit;
    assign w_scan_rd = w_scan_en && (r_idx < r_count);
    assign w_last    = r_count - CNT_W'(1);

    always_comb begin
        w_rd_en   = w_scan_rd || i_cmd.rd_last || i_cmd.rd_pick;
        w_rd_addr = r_idx[IDX_W-1:0];
        if (i_cmd.rd_last) begin
            w_rd_addr = w_last[IDX_W-1:0];
        end else if (i_cmd.rd_pick) begin
            w_rd_addr = r_rem[IDX_W-1:0];
        end
        w_wr_en   = i_cmd.wr_append || i_cmd.wr_move;
        w_wr_addr = i_cmd.wr_move ? r_pidx[IDX_W-1:0] : r_count[IDX_W-1:0];
        w_wr_data = i_cmd.wr_move ? r_rdata : r_value;
    end

    // One restoring step of random_word modulo live count, most significant bit first.
    always_comb begin
        w_trial = {r_rem, r_rnd[RND_W-1]};
        w_ge    = w_trial >= {1'b0, r_count};
        n_rem   = w_ge ? CNT_W'(w_trial - {1'b0, r_count}) : CNT_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_rnd   <= i_random_word;
        end else if (i_cmd.div_step) begin
            r_rnd   <= r_rnd << 1;
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end
        if (w_scan_rd) begin
            r_pidx <= r_idx;
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_picked <= i_cmd.res_pick ? r_rdata : '0;
            r_res_count  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_step  <= '0;
        end else begin
            if (i_cmd.wr_append) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.wr_move) begin
                r_count <= w_last;
            end
            if (i_cmd.scan_start) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (w_scan_en) begin
                r_pend <= w_scan_rd;
                if (w_scan_rd) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            if (i_cmd.div_start) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_comb begin
        o_sts.hit       = w_hit;
        o_sts.scan_done = !r_pend && (r_idx >= r_count);
        o_sts.full      = r_count >= CNT_W'(CAPACITY);
        o_sts.empty     = r_count == '0;
        o_sts.div_done  = r_step == STEP_W'(RND_W - 1);
    end

    assign o_status       = r_res_status;
    assign o_picked_value = r_res_picked;
    assign o_member_count = MC_W'(r_res_count);

endmodule

@@ sv/sirp_ctrl.sv @@
// Controller state machine of the set block: sequences search, update, modulo and result.
module sirp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [sirp_pkg::ACT_W-1:0] i_action,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  sirp_pkg::t_dp_sts   i_sts,
    output sirp_pkg::t_dp_cmd   o_cmd
);
    import sirp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SCAN    = 8'b0000_0010,
        S_REM_WR  = 8'b0000_0100,
        S_DIV     = 8'b0000_1000,
        S_PICK_RD = 8'b0001_0000,
        S_RESULT  = 8'b0010_0000,
        S_INS_WR  = 8'b0100_0000,
        S_REM_RD  = 8'b1000_0000
    } t_state;

    t_state  r_state, n_state;
    t_action r_action, n_action;
    t_status r_status, n_status;
    logic    r_pick, n_pick;
    logic    r_out_valid, n_out_valid;
    logic    w_accept;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_status    = r_status;
        n_pick      = r_pick;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.res_status = r_status;
        o_cmd.res_pick   = r_pick;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_pick     = 1'b0;
                    n_status   = ST_DONE;
                    unique case (i_action)
                        ACT_INSERT, ACT_REMOVE: begin
                            n_action         = t_action'(i_action);
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                        ACT_PICK: begin
                            if (i_sts.empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_RESULT;
                            end else begin
                                o_cmd.div_start = 1'b1;
                                n_state         = S_DIV;
                            end
                        end
                        default: begin
                            n_state = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    if (r_action == ACT_REMOVE) begin
                        n_state = S_REM_RD;
                    end else begin
                        n_status = ST_MISS;
                        n_state  = S_RESULT;
                    end
                end else if (i_sts.scan_done) begin
                    if (r_action == ACT_REMOVE) begin
                        n_status = ST_MISS;
                        n_state  = S_RESULT;
                    end else if (i_sts.full) begin
                        n_status = ST_FULL;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_INS_WR;
                    end
                end
            end
            S_INS_WR: begin
                o_cmd.wr_append = 1'b1;
                n_state         = S_RESULT;
            end
            S_REM_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_REM_WR;
            end
            S_REM_WR: begin
                o_cmd.wr_move = 1'b1;
                n_state       = S_RESULT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_PICK_RD;
                end
            end
            S_PICK_RD: begin
                o_cmd.rd_pick = 1'b1;
                n_pick        = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_action    <= ACT_INSERT;
            r_status    <= ST_DONE;
            r_pick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_action    <= n_action;
            r_status    <= n_status;
            r_pick      <= n_pick;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ sv/set_insert_remove_random_pick.sv @@
// Top level of the randomized set with insert, swap-remove and random pick.
// This block keeps a set of distinct signed 32-bit values, up to CAPACITY (64) of them, packed
// densely in an on-chip memory together with a live count. Each input item carries an action
// in s_axis_tuser (0 insert, 1 remove, 2 pick; code 3 does nothing) and a value and a random
// word in s_axis_tdata, and yields exactly one result item: a status in m_axis_tuser (0 done,
// 1 already present or not found, 2 set full, 3 set empty) and the picked value with the
// member count after the operation in m_axis_tdata. Insert and remove first scan the memory,
// one entry per cycle through its single registered read port. An insert that finds nothing
// then appends the value; a remove that finds the value at slot k copies the last entry into
// the freed slot. A pick reduces the random word modulo the count in a one-bit-per-cycle
// restoring unit, 16 steps; a pick from an empty set and action code 3 go straight to the
// result. One item is worked on at a time. The finished result sits in an output register,
// so a new item is accepted while the previous result still waits to be taken; the next
// result then waits until that one is gone. Memory contents need no clearing after reset,
// because only entries below the live count are ever read.
module set_insert_remove_random_pick (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [31:0] value, [47:32] random_word
    input  logic [sirp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] action
    input  logic [sirp_pkg::ACT_W-1:0]            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [31:0] picked_value, [38:32] member_count, upper bits zero
    output logic [sirp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [1:0] status
    output logic [sirp_pkg::ST_W-1:0]             m_axis_tuser
);
    import sirp_pkg::*;

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    t_status          w_status;
    logic [VAL_W-1:0] w_picked;
    logic [MC_W-1:0]  w_count;

    // The controller decides the sequence; the datapath holds the data payload and the set's state.
    sirp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sirp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (s_axis_tdata[VAL_W-1:0]),
        .i_random_word  (s_axis_tdata[VAL_W+RND_W-1:VAL_W]),
        .o_sts          (w_sts),
        .o_status       (w_status),
        .o_picked_value (w_picked),
        .o_member_count (w_count)
    );

    // Output packing: picked value in the low word, member count above it, zero fill.
    always_comb begin
        m_axis_tdata                         = '0;
        m_axis_tdata[VAL_W-1:0]              = w_picked;
        m_axis_tdata[VAL_W+MC_W-1:VAL_W]     = w_count;
    end

    assign m_axis_tuser = w_status;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the randomized set with insert, swap-remove and random pick.
`timescale 1ns / 100ps

module tb_top;
    import sirp_pkg::*;

    // Action code 3 is not a member of t_action; the block must ignore it.
    localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;

    // The slowest item is a scan of a full set. The receiver's stalls and the
    // sender's pauses are bounded, so about 460 items fit well inside this limit.
    localparam int RUN_LIMIT   = 400000;
    localparam int DRAIN_WAIT  = 100;
    localparam int POOL_SIZE   = 72;

    // One result item as it is predicted.
    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] picked;
        logic [MC_W-1:0]  count;
    } t_set_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] value, [47:32] random_word
    logic [ACT_W-1:0]       s_axis_tuser  = '0;   // [1:0] action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [31:0] picked_value, [38:32] member_count
    logic [ST_W-1:0]        m_axis_tuser;          // [1:0] status

    // Shadow copy of the set, updated as each item is accepted.
    logic [VAL_W-1:0] shadow_members [CAPACITY];
    int               shadow_count = 0;

    // Predicted results that have not come out of the block yet, oldest first.
    t_set_result pending_results [$];

    // Values that are reused so that inserts meet members and removes find them.
    logic [VAL_W-1:0] value_pool [POOL_SIZE];

    int error_count = 0;
    int cycle_count = 0;

    // Sender burst state: items left in the current burst.
    int burst_left = 0;

    // Receiver stall state.
    int  stall_mode        = 0;
    int  stall_mode_cycles = 0;
    int  stall_run_left    = 0;
    bit  stall_ready_level = 1'b1;

    set_insert_remove_random_pick dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("[set_insert_remove_random_pick] ERROR");
            $finish;
        end
    end

    // Receiver: moves between three modes at random: always ready, ready dropped
    // at random, and alternating runs of ready and stall.
    always @(posedge i_clk) begin
        if (stall_mode_cycles == 0) begin
            stall_mode        = $urandom_range(0, 2);
            stall_mode_cycles = $urandom_range(100, 400);
        end
        stall_mode_cycles--;
        case (stall_mode)
            0: begin
                m_axis_tready <= 1'b1;
            end
            1: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_run_left == 0) begin
                    stall_ready_level = !stall_ready_level;
                    stall_run_left    = stall_ready_level ? $urandom_range(1, 10)
                                                          : $urandom_range(1, 8);
                end
                stall_run_left--;
                m_axis_tready <= stall_ready_level;
            end
        endcase
    end

    // Works out the result of one accepted item and updates the shadow set.
    function automatic t_set_result apply_set_op(logic [ACT_W-1:0] act,
                                                 logic [VAL_W-1:0] value,
                                                 logic [RND_W-1:0] rnd);
        t_set_result res;
        int          slot;
        res.status = ST_DONE;
        res.picked = '0;
        slot       = shadow_count;
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_members[i] == value && slot == shadow_count) begin
                slot = i;
            end
        end
        if (act == ACT_INSERT) begin
            // Membership is checked before fullness.
            if (slot < shadow_count) begin
                res.status = ST_MISS;
            end else if (shadow_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                shadow_members[shadow_count] = value;
                shadow_count++;
            end
        end else if (act == ACT_REMOVE) begin
            if (slot >= shadow_count) begin
                res.status = ST_MISS;
            end else begin
                // The last live entry fills the freed slot.
                shadow_members[slot] = shadow_members[shadow_count - 1];
                shadow_count--;
            end
        end else if (act == ACT_PICK) begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.picked = shadow_members[int'(rnd) % shadow_count];
            end
        end
        res.count = MC_W'(shadow_count);
        return res;
    endfunction

    // Sends one item and records its prediction once the block has taken it.
    // Called at a rising edge; returns at the edge where the item was accepted.
    task automatic send_item(logic [ACT_W-1:0] act, logic [VAL_W-1:0] value,
                             logic [RND_W-1:0] rnd);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rnd, value};
        s_axis_tuser  <= act;
        do begin
            @(posedge i_clk);
        end while (!(s_axis_tvalid && s_axis_tready));
        pending_results.push_back(apply_set_op(act, value, rnd));
    endtask

    // Compares every result item taken from the block with the oldest prediction.
    always @(posedge i_clk) begin
        t_set_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, want.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[VAL_W-1:0] != want.picked) begin
                    $display("%0t picked_value mismatch: expected %h actual %h",
                             $time, want.picked, m_axis_tdata[VAL_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[VAL_W +: MC_W] != want.count) begin
                    $display("%0t member_count mismatch: expected %0d actual %0d",
                             $time, want.count, m_axis_tdata[VAL_W +: MC_W]);
                    error_count++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:VAL_W+MC_W] != '0) begin
                    $display("%0t tdata padding mismatch: expected 0 actual %h",
                             $time, m_axis_tdata[OUT_TDATA_W-1:VAL_W+MC_W]);
                    error_count++;
                end
            end
        end
    end

    // Random word for a pick, with the extremes favored.
    function automatic logic [RND_W-1:0] draw_random_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return RND_W'($urandom_range(0, 65535));
    endfunction

    // Edge cases on a small set: empty set, extremes of the value, duplicate
    // insert, the ignored action code, swap-remove from the front and the back,
    // and picks at both ends of the random word.
    task automatic test_directed();
        send_item(ACT_PICK,    32'h0000_0000, 16'h0000);
        send_item(ACT_PICK,    32'hFFFF_FFFF, 16'hFFFF);
        send_item(ACT_REMOVE,  32'h0000_0005, 16'h0000);
        send_item(ACT_IGNORED, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(ACT_INSERT,  32'h8000_0000, 16'h0000);
        send_item(ACT_INSERT,  32'h7FFF_FFFF, 16'hFFFF);
        send_item(ACT_INSERT,  32'h0000_0000, 16'h0000);
        send_item(ACT_INSERT,  32'hFFFF_FFFF, 16'h0000);
        send_item(ACT_INSERT,  32'h8000_0000, 16'h0000);
        send_item(ACT_IGNORED, 32'h0000_0000, 16'h0000);
        send_item(ACT_PICK,    32'h1234_5678, 16'h0000);
        send_item(ACT_PICK,    32'h0000_0000, 16'hFFFF);
        send_item(ACT_PICK,    32'h0000_0000, 16'h0006);
        // Remove from the front: the last entry moves into slot zero.
        send_item(ACT_REMOVE,  32'h8000_0000, 16'h0000);
        send_item(ACT_PICK,    32'h0000_0000, 16'h0000);
        // Remove the entry that sits in the last live slot.
        send_item(ACT_REMOVE,  32'h0000_0000, 16'h0000);
        send_item(ACT_REMOVE,  32'h0000_3039, 16'h0000);
        send_item(ACT_REMOVE,  32'h0000_0000, 16'h0000);
        send_item(ACT_INSERT,  32'h5555_5555, 16'hAAAA);
        send_item(ACT_INSERT,  32'hAAAA_AAAA, 16'h5555);
        send_item(ACT_REMOVE,  32'h7FFF_FFFF, 16'h0000);
        send_item(ACT_REMOVE,  32'hFFFF_FFFF, 16'h0000);
        send_item(ACT_REMOVE,  32'h5555_5555, 16'h0000);
        send_item(ACT_REMOVE,  32'hAAAA_AAAA, 16'h0000);
        send_item(ACT_PICK,    32'h0000_0000, 16'hFFFF);
    endtask

    // Fills the set to capacity, tries inserts against a full set, then empties
    // it again with removes of random members and picks in between.
    task automatic test_full_set();
        while (shadow_count < CAPACITY) begin
            send_item(ACT_INSERT, $urandom, draw_random_word());
        end
        send_item(ACT_INSERT, $urandom, draw_random_word());
        // A member is reported as present even though the set is full.
        send_item(ACT_INSERT, shadow_members[0], draw_random_word());
        send_item(ACT_INSERT, shadow_members[CAPACITY - 1], draw_random_word());
        send_item(ACT_PICK, $urandom, 16'hFFFF);
        send_item(ACT_PICK, $urandom, 16'h0000);
        send_item(ACT_PICK, $urandom, 16'h003F);
        send_item(ACT_REMOVE, shadow_members[$urandom_range(0, CAPACITY - 1)], 16'h0000);
        send_item(ACT_INSERT, $urandom, draw_random_word());
        send_item(ACT_IGNORED, $urandom, draw_random_word());
        while (shadow_count > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                send_item(ACT_PICK, $urandom, draw_random_word());
            end
            send_item(ACT_REMOVE, shadow_members[$urandom_range(0, shadow_count - 1)],
                      draw_random_word());
        end
    endtask

    // Random mix of all actions. The set alternates between growing and
    // shrinking phases so that its size sweeps from empty to full and back.
    task automatic test_random_mix(int n_items);
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] value;
        bit               growing;
        int               roll;
        growing = 1'b1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            value_pool[i] = $urandom;
        end
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int n = 0; n < n_items; n++) begin
            if (shadow_count == CAPACITY && $urandom_range(0, 3) == 0) begin
                growing = 1'b0;
            end else if (shadow_count == 0 && $urandom_range(0, 1) == 0) begin
                growing = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < (growing ? 60 : 20)) begin
                act = ACT_INSERT;
            end else if (roll < (growing ? 78 : 65)) begin
                act = ACT_REMOVE;
            end else if (roll < 97) begin
                act = ACT_PICK;
            end else begin
                act = ACT_IGNORED;
            end
            // Removes mostly target current members; other values come mostly
            // from the pool and now and then are fully random.
            if (act == ACT_REMOVE && shadow_count > 0 && $urandom_range(0, 9) < 6) begin
                value = shadow_members[$urandom_range(0, shadow_count - 1)];
            end else if ($urandom_range(0, 99) < 85) begin
                value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else begin
                value = $urandom;
            end
            send_item(act, value, draw_random_word());
        end
    endtask

    // Waits for every predicted result, lets the block settle, then reports.
    task automatic finish_run();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[set_insert_remove_random_pick] OK");
        end else begin
            $display("[set_insert_remove_random_pick] ERROR");
        end
        $finish;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_set();
        test_random_mix(300);
        finish_run();
    end

endmodule
